// File: sv/ate3d_pkg.sv
// ----------------------------------------------------------------------------
// ate3d_pkg
// shared types, widths and the cordic arctangent table of the transform engine
// ----------------------------------------------------------------------------
package ate3d_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_WIDTH  = 16;
   localparam int CORDIC_STEPS = 16;

   localparam int ATAN_COUNT = 24;
   localparam int CORDIC_N   = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
   localparam int STEP_W     = $clog2(ATAN_COUNT + 1);
   localparam int CORDIC_W   = 34;
   localparam int PROD_W     = 2 * COORD_WIDTH;
   localparam int ACC_W      = 2 * COORD_WIDTH + 2;
   localparam int TRIG_SH    = 30 - FRAC_BITS;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(64'sd652032874);

   // 1.0, clipped to the largest entry when it does not fit
   localparam logic signed [COORD_WIDTH-1:0] ONE_VAL =
      (FRAC_BITS <= COORD_WIDTH - 2) ? COORD_WIDTH'(64'sd1 <<< FRAC_BITS)
                                     : COORD_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
      COORD_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

   localparam logic [2:0] OP_IDENTITY  = 3'd0;
   localparam logic [2:0] OP_SCALE     = 3'd1;
   localparam logic [2:0] OP_TRANSLATE = 3'd2;
   localparam logic [2:0] OP_ROTATE    = 3'd3;
   localparam logic [2:0] OP_VERTEX    = 3'd4;

   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic [2:0]                    opcode;
      logic signed [COORD_WIDTH-1:0] value_a;
      logic signed [COORD_WIDTH-1:0] value_b;
      logic signed [COORD_WIDTH-1:0] value_c;
      logic [ANGLE_WIDTH-1:0]        rot_angle;
      logic [1:0]                    rot_axis;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
   } rsp_payload_type;

   // arctangent of 2^-i in 2^32 units per turn
   function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
      logic signed [CORDIC_W-1:0] v;
      unique case (idx)
         5'd0:  v = CORDIC_W'(64'sd536870912);
         5'd1:  v = CORDIC_W'(64'sd316933406);
         5'd2:  v = CORDIC_W'(64'sd167458907);
         5'd3:  v = CORDIC_W'(64'sd85004756);
         5'd4:  v = CORDIC_W'(64'sd42667331);
         5'd5:  v = CORDIC_W'(64'sd21354465);
         5'd6:  v = CORDIC_W'(64'sd10679838);
         5'd7:  v = CORDIC_W'(64'sd5340245);
         5'd8:  v = CORDIC_W'(64'sd2670163);
         5'd9:  v = CORDIC_W'(64'sd1335087);
         5'd10: v = CORDIC_W'(64'sd667544);
         5'd11: v = CORDIC_W'(64'sd333772);
         5'd12: v = CORDIC_W'(64'sd166886);
         5'd13: v = CORDIC_W'(64'sd83443);
         5'd14: v = CORDIC_W'(64'sd41722);
         5'd15: v = CORDIC_W'(64'sd20861);
         5'd16: v = CORDIC_W'(64'sd10430);
         5'd17: v = CORDIC_W'(64'sd5215);
         5'd18: v = CORDIC_W'(64'sd2608);
         5'd19: v = CORDIC_W'(64'sd1304);
         5'd20: v = CORDIC_W'(64'sd652);
         5'd21: v = CORDIC_W'(64'sd326);
         5'd22: v = CORDIC_W'(64'sd163);
         5'd23: v = CORDIC_W'(64'sd81);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/affine_transform_engine_3d.sv
// ----------------------------------------------------------------------------
// affine_transform_engine_3d
// running 3x4 affine matrix in q8.16 with identity, scale, translate, rotate and vertex
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                          carries
//  req      in   req_valid req_ready req_payload  opcode, values, angle, axis
//  rsp      out  rsp_valid rsp_ready rsp_payload  out_x out_y out_z
//
//  identity and translate finish in the transfer cycle itself
//  scale and vertex run on the single shared 24x24 multiplier; rotate first runs
//  the cordic shift-add loop and the quadrant fold, then the same multiplier
//  reset (synchronous) reloads identity and empties the pipeline
//  req_ready is low while an item is in work; a vertex waits for rsp to drain
//
module affine_transform_engine_3d (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ate3d_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ate3d_pkg::rsp_payload_type rsp_payload
);
   import ate3d_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CORDIC, ST_TRIG, ST_MAC, ST_DRAIN, ST_OUT
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [3:0] idx;
   } tag_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   state_type                  state_ff;
   logic [2:0]                 op_ff;
   logic [1:0]                 axis_ff;
   logic [1:0]                 quad_ff;
   coord_type                  v_ff   [3];
   coord_type                  m_ff   [12];
   coord_type                  sh_ff  [12];
   coord_type                  outt_ff[3];
   coord_type                  cos_ff, sin_ff;
   logic signed [CORDIC_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [1:0]                 r_ff, c_ff, k_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   tag_type                    s1_ff, s2_ff, s1_in;
   logic                       rsp_valid_ff;
   rsp_payload_type            rsp_ff;

   // rotation coefficient, row r column k
   function automatic coord_type rot_coef(input logic [1:0] axis, input logic [1:0] r,
                                          input logic [1:0] k, input coord_type c,
                                          input coord_type s);
      coord_type v;
      v = '0;
      if (axis == AXIS_Y) begin
         unique case ({r, k})
            4'b0000, 4'b1010: v = c;
            4'b0010:          v = s;
            4'b1000:          v = -s;
            4'b0101:          v = ONE_VAL;
            default:          v = '0;
         endcase
      end else if (axis == AXIS_Z) begin
         unique case ({r, k})
            4'b0000, 4'b0101: v = c;
            4'b0001:          v = -s;
            4'b0100:          v = s;
            4'b1010:          v = ONE_VAL;
            default:          v = '0;
         endcase
      end else begin
         unique case ({r, k})
            4'b0101, 4'b1010: v = c;
            4'b0110:          v = -s;
            4'b1001:          v = s;
            4'b0000:          v = ONE_VAL;
            default:          v = '0;
         endcase
      end
      return v;
   endfunction

   // round half up from the exact sum, then clip
   function automatic coord_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      t = (acc + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (t > ACC_W'(COORD_MAX))      return COORD_MAX;
      else if (t < ACC_W'(COORD_MIN)) return COORD_MIN;
      else                            return t[COORD_WIDTH-1:0];
   endfunction

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [COORD_WIDTH:0] t;
      t = (COORD_WIDTH+1)'(a) + (COORD_WIDTH+1)'(b);
      if (t > (COORD_WIDTH+1)'(COORD_MAX))      return COORD_MAX;
      else if (t < (COORD_WIDTH+1)'(COORD_MIN)) return COORD_MIN;
      else                                      return t[COORD_WIDTH-1:0];
   endfunction

   // operand select for the shared multiplier
   logic       is_vtx;
   logic [1:0] last_k, last_c;
   logic [3:0] rd_idx;
   coord_type  m_rd, v_rd, a_op, b_op;

   assign is_vtx = (op_ff == OP_VERTEX);
   assign last_k = is_vtx ? 2'd3 : 2'd2;
   assign last_c = is_vtx ? 2'd0 : 2'd3;
   assign rd_idx = is_vtx ? {r_ff, k_ff} : {k_ff, c_ff};
   assign m_rd   = m_ff[rd_idx];
   assign v_rd   = v_ff[is_vtx ? k_ff : r_ff];

   always_comb begin
      unique case (op_ff)
         OP_VERTEX: begin
            a_op = m_rd;
            b_op = (k_ff == 2'd3) ? ONE_VAL : v_rd;
         end
         OP_SCALE: begin
            a_op = (k_ff == r_ff) ? v_rd : '0;
            b_op = m_rd;
         end
         default: begin
            a_op = rot_coef(axis_ff, r_ff, k_ff, cos_ff, sin_ff);
            b_op = m_rd;
         end
      endcase
   end

   assign prod_in = PROD_W'(a_op) * PROD_W'(b_op);
   assign acc_in  = (s1_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);

   always_comb begin
      s1_in.valid = (state_ff == ST_MAC);
      s1_in.first = (k_ff == 2'd0);
      s1_in.last  = (k_ff == last_k);
      s1_in.idx   = is_vtx ? {2'b00, r_ff} : {r_ff, c_ff};
   end

   // cordic shift-add step
   logic signed [CORDIC_W-1:0] dx, dy, at;
   logic signed [CORDIC_W-1:0] cq_full, sq_full;
   coord_type                  cq, sq;

   assign dx      = cy_ff >>> step_ff;
   assign dy      = cx_ff >>> step_ff;
   assign at      = atan_lut(step_ff);
   assign cq_full = (cx_ff + (CORDIC_W'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
   assign sq_full = (cy_ff + (CORDIC_W'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
   assign cq      = cq_full[COORD_WIDTH-1:0];
   assign sq      = sq_full[COORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      // writeback of a finished sum
      if (s2_ff.valid) begin
         if (is_vtx) outt_ff[s2_ff.idx[1:0]] <= round_sat(acc_ff);
         else        sh_ff[s2_ff.idx]        <= round_sat(acc_ff);
      end

      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_ff        <= '0;
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 12; i++)
            m_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE_VAL : '0;
      end else begin
         s1_ff       <= s1_in;
         s2_ff.valid <= s1_ff.valid && s1_ff.last;
         s2_ff.first <= s1_ff.first;
         s2_ff.last  <= s1_ff.last;
         s2_ff.idx   <= s1_ff.idx;
         // result register: load when free or being taken, else clear on transfer
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)                      rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff   <= req_payload.opcode;
                  axis_ff <= req_payload.rot_axis;
                  v_ff[0] <= req_payload.value_a;
                  v_ff[1] <= req_payload.value_b;
                  v_ff[2] <= req_payload.value_c;
                  r_ff    <= '0;
                  c_ff    <= '0;
                  k_ff    <= '0;
                  quad_ff <= req_payload.rot_angle[ANGLE_WIDTH-1 -: 2];
                  cx_ff   <= CORDIC_GAIN;
                  cy_ff   <= '0;
                  cz_ff   <= CORDIC_W'({req_payload.rot_angle[ANGLE_WIDTH-3:0],
                                        (32 - ANGLE_WIDTH)'(0)});
                  step_ff <= '0;
                  unique case (req_payload.opcode)
                     OP_IDENTITY: begin
                        for (int i = 0; i < 12; i++)
                           m_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE_VAL : '0;
                     end
                     OP_TRANSLATE: begin
                        m_ff[3]  <= sat_add(m_ff[3],  req_payload.value_a);
                        m_ff[7]  <= sat_add(m_ff[7],  req_payload.value_b);
                        m_ff[11] <= sat_add(m_ff[11], req_payload.value_c);
                     end
                     OP_SCALE, OP_VERTEX: state_ff <= ST_MAC;
                     OP_ROTATE:           state_ff <= ST_CORDIC;
                     default:             state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_CORDIC: begin
               if (!cz_ff[CORDIC_W-1]) begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + at;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_N - 1)) state_ff <= ST_TRIG;
            end
            ST_TRIG: begin
               // quadrant fold
               unique case (quad_ff)
                  2'd0: begin cos_ff <= cq;  sin_ff <= sq;  end
                  2'd1: begin cos_ff <= -sq; sin_ff <= cq;  end
                  2'd2: begin cos_ff <= -cq; sin_ff <= -sq; end
                  default: begin cos_ff <= sq; sin_ff <= -cq; end
               endcase
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               // k innermost, then row, then column
               if (k_ff == last_k) begin
                  k_ff <= '0;
                  if (r_ff == 2'd2) begin
                     r_ff <= '0;
                     c_ff <= c_ff + 1'b1;
                     if (c_ff == last_c) state_ff <= ST_DRAIN;
                  end else begin
                     r_ff <= r_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!s1_ff.valid && !s2_ff.valid) begin
                  if (is_vtx) begin
                     state_ff <= ST_OUT;
                  end else begin
                     for (int i = 0; i < 12; i++) m_ff[i] <= sh_ff[i];
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.out_x <= outt_ff[0];
                  rsp_ff.out_y <= outt_ff[1];
                  rsp_ff.out_z <= outt_ff[2];
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // no product in flight once the sequencer is back to idle
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_ff.valid && !s2_ff.valid))
      else $error("pipeline busy while idle");

   // a writeback follows only a group-closing issue
   a_wb_follows: assert property (@(posedge clock) disable iff (reset)
      s2_ff.valid |-> $past(s1_ff.valid && s1_ff.last))
      else $error("writeback without closing product");

   // cordic iteration count stays within the table
   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (step_ff < STEP_W'(CORDIC_N)))
      else $error("cordic step overrun");

   // the result register is loaded only when free or being taken
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("result overwritten");

endmodule
